// File: hw/rtl/ytt_pkg.sv
package ytt_pkg;

    localparam int VW = 40;
    localparam int AW = 36;
    localparam int PW = VW + 32;
    localparam int TABLE_LEN = 24;

    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] THRESH_Q30  = 64'sd1073742;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032875;

    localparam logic signed [63:0] ATAN_Q30 [0:TABLE_LEN-1] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };

    localparam logic CFG_TURN_RATE       = 1'b0;
    localparam logic CFG_TARGET_IS_POINT = 1'b1;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [AW-1:0] t_ang;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        logic [31:0] lz;
        logic [31:0] lx;
        logic [31:0] uz;
        logic [31:0] ux;
        logic [31:0] rz;
        logic [31:0] rx;
    } t_basis;

    typedef struct packed {
        t_vec   re_t;
        t_vec   im_t;
        t_vec   re_l;
        t_vec   im_l;
        t_ang   ang_t;
        t_ang   ang_l;
        t_ang   step;
        logic   skip;
        t_basis b;
    } t_vec_lane;

    typedef struct packed {
        t_ang   diff;
        t_ang   step;
        logic   skip;
        t_basis b;
    } t_mid;

    typedef struct packed {
        t_vec   re0;
        t_vec   im0;
        t_vec   re1;
        t_vec   im1;
        t_vec   re2;
        t_vec   im2;
        t_ang   res;
        logic   turn;
        t_basis b;
    } t_rot_lane;

    typedef struct packed {
        t_prod  prx;
        t_prod  prz;
        t_prod  pux;
        t_prod  puz;
        t_prod  plx;
        t_prod  plz;
        logic   turn;
        t_basis b;
    } t_gain;

    typedef struct packed {
        logic [191:0] data;
        logic         turn;
    } t_out;

    function automatic t_ang q30_ang(input int frac, input logic signed [63:0] a);
        logic signed [63:0] r;
        r = (a + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
        return r[AW-1:0];
    endfunction

    function automatic t_vec sext32(input logic [31:0] v);
        return {{(VW-32){v[31]}}, v};
    endfunction

endpackage

// File: hw/rtl/ytt_vec_cell.sv
module ytt_vec_cell import ytt_pkg::*; #(
    parameter int IDX       = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_vec_lane i_lane,
    output logic      o_valid,
    output t_vec_lane o_lane
);

    localparam t_ang ANG = q30_ang(FRAC_BITS, ATAN_Q30[IDX]);

    logic      r_valid;
    t_vec_lane r_lane;
    t_vec_lane n_lane;

    always_comb begin
        n_lane = i_lane;
        if (!i_lane.im_t[VW-1]) begin
            n_lane.re_t  = i_lane.re_t + (i_lane.im_t >>> IDX);
            n_lane.im_t  = i_lane.im_t - (i_lane.re_t >>> IDX);
            n_lane.ang_t = i_lane.ang_t + ANG;
        end else begin
            n_lane.re_t  = i_lane.re_t - (i_lane.im_t >>> IDX);
            n_lane.im_t  = i_lane.im_t + (i_lane.re_t >>> IDX);
            n_lane.ang_t = i_lane.ang_t - ANG;
        end
        if (!i_lane.im_l[VW-1]) begin
            n_lane.re_l  = i_lane.re_l + (i_lane.im_l >>> IDX);
            n_lane.im_l  = i_lane.im_l - (i_lane.re_l >>> IDX);
            n_lane.ang_l = i_lane.ang_l + ANG;
        end else begin
            n_lane.re_l  = i_lane.re_l - (i_lane.im_l >>> IDX);
            n_lane.im_l  = i_lane.im_l + (i_lane.re_l >>> IDX);
            n_lane.ang_l = i_lane.ang_l - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: hw/rtl/ytt_rot_cell.sv
module ytt_rot_cell import ytt_pkg::*; #(
    parameter int IDX       = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_rot_lane i_lane,
    output logic      o_valid,
    output t_rot_lane o_lane
);

    localparam t_ang ANG = q30_ang(FRAC_BITS, ATAN_Q30[IDX]);

    logic      r_valid;
    t_rot_lane r_lane;
    t_rot_lane n_lane;

    always_comb begin
        n_lane = i_lane;
        if (!i_lane.res[AW-1]) begin
            n_lane.re0 = i_lane.re0 - (i_lane.im0 >>> IDX);
            n_lane.im0 = i_lane.im0 + (i_lane.re0 >>> IDX);
            n_lane.re1 = i_lane.re1 - (i_lane.im1 >>> IDX);
            n_lane.im1 = i_lane.im1 + (i_lane.re1 >>> IDX);
            n_lane.re2 = i_lane.re2 - (i_lane.im2 >>> IDX);
            n_lane.im2 = i_lane.im2 + (i_lane.re2 >>> IDX);
            n_lane.res = i_lane.res - ANG;
        end else begin
            n_lane.re0 = i_lane.re0 + (i_lane.im0 >>> IDX);
            n_lane.im0 = i_lane.im0 - (i_lane.re0 >>> IDX);
            n_lane.re1 = i_lane.re1 + (i_lane.im1 >>> IDX);
            n_lane.im1 = i_lane.im1 - (i_lane.re1 >>> IDX);
            n_lane.re2 = i_lane.re2 + (i_lane.im2 >>> IDX);
            n_lane.im2 = i_lane.im2 - (i_lane.re2 >>> IDX);
            n_lane.res = i_lane.res + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: hw/rtl/yaw_turn_toward_target.sv
// Throughput: one beat per cycle while the input is not stalled; each CORDIC iteration is its own cell in the chain.
// The input side stalls only when the output register and its skid stage are both full.
// Reset is synchronous and active low; it clears all valid flags and the skid stage,
// and sets turn_rate to 100.0 rad/s and target_is_point to 1.
module yaw_turn_toward_target import ytt_pkg::*; #(
    parameter int FRAC_BITS        = 16,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [25:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // target_x, target_z, position_x, position_z, right_x_in, right_z_in,
    // up_x_in, up_z_in, look_x_in, look_z_in, time_step
    input  logic [335:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // right_x_out, right_z_out, up_x_out, up_z_out, look_x_out, look_z_out
    output logic [191:0] o_m_axis_tdata,
    // turned
    output logic         o_m_axis_tuser
);

    localparam int   N      = ANGLE_ITERATIONS;
    localparam t_ang HP     = q30_ang(FRAC_BITS, HALF_PI_Q30);
    localparam t_ang PI_A   = q30_ang(FRAC_BITS, PI_Q30);
    localparam t_ang NEG_PI = -PI_A;
    localparam t_ang TWO_PI = PI_A + PI_A;
    localparam t_ang THR    = q30_ang(FRAC_BITS, THRESH_Q30);

    logic [25:0] r_turn_rate;
    logic        r_target_is_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_rate       <= 26'd6553600;
            r_target_is_point <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TURN_RATE:       r_turn_rate       <= i_cfg_data;
                CFG_TARGET_IS_POINT: r_target_is_point <= i_cfg_data[0];
                default:             r_turn_rate       <= r_turn_rate;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic en;
    logic r_skid_valid;
    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    // Input stage: target vector (difference if a point), step angle and quadrant fold for vectoring.
    t_vec        tx, tz, lxv, lzv;
    logic [41:0] prod, prod_sh;
    t_vec_lane   n_v0;

    always_comb begin
        tx  = sext32(i_s_axis_tdata[31:0]);
        tz  = sext32(i_s_axis_tdata[63:32]);
        if (r_target_is_point) begin
            tx = tx - sext32(i_s_axis_tdata[95:64]);
            tz = tz - sext32(i_s_axis_tdata[127:96]);
        end
        lxv     = sext32(i_s_axis_tdata[287:256]);
        lzv     = sext32(i_s_axis_tdata[319:288]);
        prod    = {16'd0, r_turn_rate} * {26'd0, i_s_axis_tdata[335:320]};
        prod_sh = prod >> (32 - FRAC_BITS);
        n_v0.b  = i_s_axis_tdata[319:128];
        n_v0.step  = {1'b0, prod_sh[AW-2:0]};
        n_v0.skip  = (lxv == '0 && lzv == '0) || (tx == '0 && tz == '0);
        n_v0.re_t  = tz;
        n_v0.im_t  = tx;
        n_v0.ang_t = '0;
        if (tz[VW-1]) begin
            if (!tx[VW-1]) begin
                n_v0.re_t  = tx;
                n_v0.im_t  = -tz;
                n_v0.ang_t = HP;
            end else begin
                n_v0.re_t  = -tx;
                n_v0.im_t  = tz;
                n_v0.ang_t = -HP;
            end
        end
        n_v0.re_l  = lzv;
        n_v0.im_l  = lxv;
        n_v0.ang_l = '0;
        if (lzv[VW-1]) begin
            if (!lxv[VW-1]) begin
                n_v0.re_l  = lxv;
                n_v0.im_l  = -lzv;
                n_v0.ang_l = HP;
            end else begin
                n_v0.re_l  = -lxv;
                n_v0.im_l  = lzv;
                n_v0.ang_l = -HP;
            end
        end
    end

    logic      vv [0:N];
    t_vec_lane vq [0:N];
    logic      r_v0;
    t_vec_lane r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q0 <= n_v0;
        end
    end

    assign vv[0] = r_v0;
    assign vq[0] = r_q0;

    for (genvar g = 0; g < N; g++) begin : g_vec
        ytt_vec_cell #(.IDX(g), .FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vv[g]),
            .i_lane  (vq[g]),
            .o_valid (vv[g+1]),
            .o_lane  (vq[g+1])
        );
    end

    // Middle stages: heading difference, wrap into (-pi, pi], rotation setup.
    logic r_m1_valid, r_m2_valid;
    t_mid r_m1, r_m2, n_m1, n_m2;
    t_ang d, mag, th;

    always_comb begin
        n_m1.diff = vq[N].ang_t - vq[N].ang_l;
        n_m1.step = vq[N].step;
        n_m1.skip = vq[N].skip;
        n_m1.b    = vq[N].b;
        d = r_m1.diff;
        for (int k = 0; k < 2; k++) begin
            if (d > PI_A) begin
                d = d - TWO_PI;
            end
            if (d <= NEG_PI) begin
                d = d + TWO_PI;
            end
        end
        n_m2      = r_m1;
        n_m2.diff = d;
    end

    t_rot_lane n_r0, r_r0;
    logic      r_r0_valid;

    always_comb begin
        mag       = r_m2.diff[AW-1] ? -r_m2.diff : r_m2.diff;
        th        = (r_m2.step < mag) ? r_m2.step : mag;
        if (r_m2.diff[AW-1]) begin
            th = -th;
        end
        n_r0.b    = r_m2.b;
        n_r0.turn = !r_m2.skip && (mag >= THR);
        n_r0.re0  = sext32(r_m2.b.rz);
        n_r0.im0  = sext32(r_m2.b.rx);
        n_r0.re1  = sext32(r_m2.b.uz);
        n_r0.im1  = sext32(r_m2.b.ux);
        n_r0.re2  = sext32(r_m2.b.lz);
        n_r0.im2  = sext32(r_m2.b.lx);
        n_r0.res  = th;
        if (th > HP) begin
            n_r0.re0 = -sext32(r_m2.b.rx);
            n_r0.im0 = sext32(r_m2.b.rz);
            n_r0.re1 = -sext32(r_m2.b.ux);
            n_r0.im1 = sext32(r_m2.b.uz);
            n_r0.re2 = -sext32(r_m2.b.lx);
            n_r0.im2 = sext32(r_m2.b.lz);
            n_r0.res = th - HP;
        end else if (th < -HP) begin
            n_r0.re0 = sext32(r_m2.b.rx);
            n_r0.im0 = -sext32(r_m2.b.rz);
            n_r0.re1 = sext32(r_m2.b.ux);
            n_r0.im1 = -sext32(r_m2.b.uz);
            n_r0.re2 = sext32(r_m2.b.lx);
            n_r0.im2 = -sext32(r_m2.b.lz);
            n_r0.res = th + HP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_r0_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= vv[N];
            r_m2_valid <= r_m1_valid;
            r_r0_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_r0 <= n_r0;
        end
    end

    logic      rv [0:N];
    t_rot_lane rq [0:N];
    assign rv[0] = r_r0_valid;
    assign rq[0] = r_r0;

    for (genvar g = 0; g < N; g++) begin : g_rot
        ytt_rot_cell #(.IDX(g), .FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (rv[g]),
            .i_lane  (rq[g]),
            .o_valid (rv[g+1]),
            .o_lane  (rq[g+1])
        );
    end

    // Gain correction products.
    t_gain r_g;
    logic  r_g_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= rv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g.prx  <= rq[N].im0 * GAIN_Q30;
            r_g.prz  <= rq[N].re0 * GAIN_Q30;
            r_g.pux  <= rq[N].im1 * GAIN_Q30;
            r_g.puz  <= rq[N].re1 * GAIN_Q30;
            r_g.plx  <= rq[N].im2 * GAIN_Q30;
            r_g.plz  <= rq[N].re2 * GAIN_Q30;
            r_g.turn <= rq[N].turn;
            r_g.b    <= rq[N].b;
        end
    end

    function automatic logic [31:0] gain_sat(input t_prod p);
        t_prod s;
        s = (p + (t_prod'(1) <<< 29)) >>> 30;
        if (s > t_prod'(64'sd2147483647)) begin
            return 32'h7FFF_FFFF;
        end else if (s < -t_prod'(64'sd2147483648)) begin
            return 32'h8000_0000;
        end
        return s[31:0];
    endfunction

    t_out n_out, r_out, r_skid;
    logic r_out_valid;

    always_comb begin
        n_out.turn = r_g.turn;
        if (r_g.turn) begin
            n_out.data = {gain_sat(r_g.plz), gain_sat(r_g.plx), gain_sat(r_g.puz),
                          gain_sat(r_g.pux), gain_sat(r_g.prz), gain_sat(r_g.prx)};
        end else begin
            n_out.data = {r_g.b.lz, r_g.b.lx, r_g.b.uz, r_g.b.ux, r_g.b.rz, r_g.b.rx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en && r_g_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_g_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out <= n_out;
            end else begin
                r_skid <= n_out;
            end
        end else if (i_m_axis_tready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = r_out.turn;

endmodule

// File: hw/rtl/ytt_checker.sv
module ytt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [191:0] o_m_axis_tdata,
    input logic         o_m_axis_tuser
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Output beat changed while stalled.");

    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("Input stalled with no output beat waiting.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("Input stalled without an output stall.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("Block not idle after reset.");

endmodule

bind yaw_turn_toward_target ytt_checker u_ytt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
